FILE: rtl/pct_pkg.sv
// Shared constants and types for the polygon cut triangulator.
`default_nettype none

package pct_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int MAX_CUTS     = MAX_VERTICES - 3;
  localparam int MAX_TRIS     = MAX_VERTICES - 2;

  localparam int VID_W  = 32;
  localparam int CUT_W  = 4;
  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int CCNT_W = $clog2(MAX_CUTS + 1);
  localparam int CIDX_W = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int TCNT_W = $clog2(MAX_TRIS + 1);
  localparam int TIDX_W = (MAX_TRIS > 1) ? $clog2(MAX_TRIS) : 1;
  localparam int FND_W  = $clog2(MAX_CUTS + MAX_VERTICES + 1);
  localparam int CMP_W  = (VCNT_W > CUT_W) ? VCNT_W : CUT_W;

  localparam logic MODE_VERTEX = 1'b0;
  localparam logic MODE_CUT    = 1'b1;

  localparam logic [MAX_VERTICES-1:0] ROW_LSB = MAX_VERTICES'(1);

  typedef struct packed {
    logic                    clr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [MAX_VERTICES-1:0] wr_data;
  } em_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/pct_edge_matrix.sv
// Directed edge matrix with one row read port, one row write port and a bulk clear.
`default_nettype none

module pct_edge_matrix (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire pct_pkg::em_cmd_t                cmd,
  input  wire logic [pct_pkg::IDX_W-1:0]       rd_addr,
  output logic      [pct_pkg::MAX_VERTICES-1:0] rd_row
);
  import pct_pkg::*;

  logic [MAX_VERTICES-1:0] rows_r [MAX_VERTICES];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      rows_r <= '{default: '0};
    end else if (cmd.wr_en) begin
      rows_r[cmd.wr_addr] <= cmd.wr_data;
    end
  end

  assign rd_row = rows_r[rd_addr];

endmodule

`default_nettype wire

FILE: rtl/polygon_cut_triangulator.sv
// Top level: loads one face, cuts triangles through a sequenced edge matrix, emits them.
//
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid / in_ready    | mode, vertex_id, cut_from, cut_to, face_end
// out     | output    | out_valid / out_ready  | corner_one..three, last_triangle, face_error
//
// A vertex or cut item is taken while the block is idle.
// After the face end item, with n vertices and k cuts, the block writes the outer edges, then
// the cut edges; for each valid cut, then each outer edge left in the matrix, it reads row b and
// searches the edge matrix row by row, with at most n + k searched edges, closes each pass and
// at last evaluates the face. Each triangle is then read corner by corner through the single
// vertex store read port and held while out_ready stays low. Synchronous active-low reset
// clears the control state and the edge matrix, but not the stores or the output corners.
`default_nettype none

module polygon_cut_triangulator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_mode,
  input  wire logic [pct_pkg::VID_W-1:0]   in_vertex_id,
  input  wire logic [pct_pkg::CUT_W-1:0]   in_cut_from,
  input  wire logic [pct_pkg::CUT_W-1:0]   in_cut_to,
  input  wire logic                        in_face_end,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [pct_pkg::VID_W-1:0]   out_corner_one,
  output logic      [pct_pkg::VID_W-1:0]   out_corner_two,
  output logic      [pct_pkg::VID_W-1:0]   out_corner_three,
  output logic                             out_last_triangle,
  output logic                             out_face_error
);
  import pct_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BUILD_OUTER,
    S_BUILD_CUT,
    S_CUT_SEL,
    S_ROWB,
    S_SEARCH,
    S_CLR_B,
    S_FINAL_SEL,
    S_EVAL,
    S_RD_C,
    S_RD_B,
    S_RD_A,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CUT_W-1:0] to;
    logic [CUT_W-1:0] from;
  } cut_t;

  typedef struct packed {
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] a;
  } tri_t;

  state_t                  state_r, state_nxt;
  logic [VCNT_W-1:0]       vcount_r, vcount_nxt;
  logic [CCNT_W-1:0]       ccount_r, ccount_nxt;
  logic [TCNT_W-1:0]       tcount_r, tcount_nxt;
  logic [FND_W-1:0]        found_r, found_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    err_r, err_nxt;
  logic                    final_r, final_nxt;
  logic [VCNT_W-1:0]       idx_r, idx_nxt;
  logic [VCNT_W-1:0]       c_r, c_nxt;
  logic [IDX_W-1:0]        a_r, a_nxt;
  logic [IDX_W-1:0]        b_r, b_nxt;
  logic [MAX_VERTICES-1:0] rowb_r, rowb_nxt;
  logic [TCNT_W-1:0]       t_r, t_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VID_W-1:0]        out_c_r, out_c_nxt;
  logic [VID_W-1:0]        out_b_r, out_b_nxt;
  logic [VID_W-1:0]        out_a_r, out_a_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_err_r, out_err_nxt;

  logic [VID_W-1:0]        vstore_r [MAX_VERTICES];
  cut_t                    cstore_r [MAX_CUTS];
  tri_t                    tstore_r [MAX_TRIS];

  logic                    vwr_en;
  logic                    cwr_en;
  logic                    twr_en;
  logic [IDX_W-1:0]        vaddr;
  logic [VID_W-1:0]        vrd;
  cut_t                    cut_sel;
  tri_t                    tri_sel;
  logic                    cut_ok;
  logic [IDX_W-1:0]        cut_a;
  logic [IDX_W-1:0]        cut_b;
  logic [IDX_W-1:0]        prev_i;
  logic                    is_last;
  em_cmd_t                 em_cmd;
  logic [IDX_W-1:0]        em_rd_addr;
  logic [MAX_VERTICES-1:0] em_rd_row;

  function automatic logic [IDX_W-1:0] prev_idx(input logic [VCNT_W-1:0] i,
                                                input logic [VCNT_W-1:0] n);
    if (i == '0) begin
      return IDX_W'(n - VCNT_W'(1));
    end
    return IDX_W'(i - VCNT_W'(1));
  endfunction

  pct_edge_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (em_cmd),
    .rd_addr (em_rd_addr),
    .rd_row  (em_rd_row)
  );

  assign in_ready          = (state_r == S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_corner_one    = out_c_r;
  assign out_corner_two    = out_b_r;
  assign out_corner_three  = out_a_r;
  assign out_last_triangle = out_last_r;
  assign out_face_error    = out_err_r;

  assign cut_sel = cstore_r[idx_r[CIDX_W-1:0]];
  assign tri_sel = tstore_r[t_r[TIDX_W-1:0]];
  assign cut_ok  = (CMP_W'(cut_sel.from) < CMP_W'(vcount_r)) &&
                   (CMP_W'(cut_sel.to) < CMP_W'(vcount_r));
  assign cut_a   = IDX_W'(cut_sel.from);
  assign cut_b   = IDX_W'(cut_sel.to);
  assign prev_i  = prev_idx(idx_r, vcount_r);
  assign is_last = ((t_r + TCNT_W'(1)) == tcount_r);
  assign vrd     = vstore_r[vaddr];

  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    ccount_nxt    = ccount_r;
    tcount_nxt    = tcount_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;
    err_nxt       = err_r;
    final_nxt     = final_r;
    idx_nxt       = idx_r;
    c_nxt         = c_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    rowb_nxt      = rowb_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r;
    out_c_nxt     = out_c_r;
    out_b_nxt     = out_b_r;
    out_a_nxt     = out_a_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    vwr_en        = 1'b0;
    cwr_en        = 1'b0;
    twr_en        = 1'b0;
    vaddr         = tri_sel.c;
    em_cmd        = '0;
    em_rd_addr    = b_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            MODE_VERTEX: begin
              if (vcount_r < VCNT_W'(MAX_VERTICES)) begin
                vwr_en     = 1'b1;
                vcount_nxt = vcount_r + VCNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            MODE_CUT: begin
              if (ccount_r < CCNT_W'(MAX_CUTS)) begin
                cwr_en     = 1'b1;
                ccount_nxt = ccount_r + CCNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (in_face_end) begin
            idx_nxt   = '0;
            state_nxt = S_BUILD_OUTER;
          end
        end
      end
      S_BUILD_OUTER: begin
        if (idx_r == vcount_r) begin
          idx_nxt   = '0;
          state_nxt = S_BUILD_CUT;
        end else begin
          em_cmd.wr_en   = 1'b1;
          em_cmd.wr_addr = idx_r[IDX_W-1:0];
          em_cmd.wr_data = ROW_LSB << prev_i;
          idx_nxt        = idx_r + VCNT_W'(1);
        end
      end
      S_BUILD_CUT: begin
        if (idx_r == VCNT_W'(ccount_r)) begin
          idx_nxt   = '0;
          state_nxt = S_CUT_SEL;
        end else begin
          if (cut_ok) begin
            em_rd_addr     = cut_b;
            em_cmd.wr_en   = 1'b1;
            em_cmd.wr_addr = cut_b;
            em_cmd.wr_data = em_rd_row | (ROW_LSB << cut_a);
          end
          idx_nxt = idx_r + VCNT_W'(1);
        end
      end
      S_CUT_SEL: begin
        if (idx_r == VCNT_W'(ccount_r)) begin
          idx_nxt   = '0;
          final_nxt = 1'b1;
          state_nxt = S_FINAL_SEL;
        end else begin
          idx_nxt = idx_r + VCNT_W'(1);
          if (cut_ok) begin
            a_nxt     = cut_a;
            b_nxt     = cut_b;
            state_nxt = S_ROWB;
          end
        end
      end
      S_ROWB: begin
        em_rd_addr = b_r;
        rowb_nxt   = em_rd_row;
        c_nxt      = '0;
        state_nxt  = S_SEARCH;
      end
      S_SEARCH: begin
        em_rd_addr = c_r[IDX_W-1:0];
        if (c_r == vcount_r) begin
          state_nxt = final_r ? S_FINAL_SEL : S_CUT_SEL;
        end else if (rowb_r[c_r[IDX_W-1:0]] && em_rd_row[a_r]) begin
          em_cmd.wr_en   = 1'b1;
          em_cmd.wr_addr = c_r[IDX_W-1:0];
          em_cmd.wr_data = em_rd_row & ~(ROW_LSB << a_r);
          found_nxt      = found_r + FND_W'(1);
          if (tcount_r < TCNT_W'(MAX_TRIS)) begin
            twr_en     = 1'b1;
            tcount_nxt = tcount_r + TCNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          state_nxt = S_CLR_B;
        end else begin
          c_nxt = c_r + VCNT_W'(1);
        end
      end
      S_CLR_B: begin
        em_rd_addr     = b_r;
        em_cmd.wr_en   = 1'b1;
        em_cmd.wr_addr = b_r;
        em_cmd.wr_data = em_rd_row & ~(ROW_LSB << c_r[IDX_W-1:0]);
        state_nxt      = final_r ? S_FINAL_SEL : S_CUT_SEL;
      end
      S_FINAL_SEL: begin
        em_rd_addr = idx_r[IDX_W-1:0];
        if (idx_r == vcount_r) begin
          state_nxt = S_EVAL;
        end else begin
          idx_nxt = idx_r + VCNT_W'(1);
          if (em_rd_row[prev_i]) begin
            a_nxt     = idx_r[IDX_W-1:0];
            b_nxt     = prev_i;
            state_nxt = S_ROWB;
          end
        end
      end
      S_EVAL: begin
        err_nxt = ovf_r || (vcount_r < VCNT_W'(3)) ||
                  ((CMP_W + 1)'(ccount_r) + (CMP_W + 1)'(3) != (CMP_W + 1)'(vcount_r)) ||
                  (found_r != FND_W'(ccount_r) + FND_W'(1)) ||
                  (tcount_r == '0);
        t_nxt   = '0;
        if (tcount_r == '0) begin
          out_c_nxt     = '0;
          out_b_nxt     = '0;
          out_a_nxt     = '0;
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          state_nxt = S_RD_C;
        end
      end
      S_RD_C: begin
        vaddr     = tri_sel.c;
        out_c_nxt = vrd;
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        vaddr     = tri_sel.b;
        out_b_nxt = vrd;
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        vaddr         = tri_sel.a;
        out_a_nxt     = vrd;
        out_last_nxt  = is_last;
        out_err_nxt   = is_last && err_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            vcount_nxt = '0;
            ccount_nxt = '0;
            tcount_nxt = '0;
            found_nxt  = '0;
            ovf_nxt    = 1'b0;
            err_nxt    = 1'b0;
            final_nxt  = 1'b0;
            em_cmd.clr = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            t_nxt     = t_r + TCNT_W'(1);
            state_nxt = S_RD_C;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      ccount_r    <= '0;
      tcount_r    <= '0;
      found_r     <= '0;
      ovf_r       <= 1'b0;
      err_r       <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= '0;
      c_r         <= '0;
      a_r         <= '0;
      b_r         <= '0;
      rowb_r      <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_err_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      ccount_r    <= ccount_nxt;
      tcount_r    <= tcount_nxt;
      found_r     <= found_nxt;
      ovf_r       <= ovf_nxt;
      err_r       <= err_nxt;
      final_r     <= final_nxt;
      idx_r       <= idx_nxt;
      c_r         <= c_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      rowb_r      <= rowb_nxt;
      t_r         <= t_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_err_r   <= out_err_nxt;
    end
    out_c_r <= out_c_nxt;
    out_b_r <= out_b_nxt;
    out_a_r <= out_a_nxt;
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vstore_r[vcount_r[IDX_W-1:0]] <= in_vertex_id;
    end
    if (cwr_en) begin
      cstore_r[ccount_r[CIDX_W-1:0]] <= '{to: in_cut_to, from: in_cut_from};
    end
    if (twr_en) begin
      tstore_r[tcount_r[TIDX_W-1:0]] <= '{c: c_r[IDX_W-1:0], b: b_r, a: a_r};
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result transaction is pending");

  a_tcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcount_r <= TCNT_W'(MAX_TRIS))
    else $error("triangle count exceeds the result limit");

  a_err_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_face_error) |-> out_last_triangle)
    else $error("face error shown on a result that is not the last");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_triangle) |=> (in_ready && !out_valid))
    else $error("block not idle after the last result transaction");
`endif

endmodule

`default_nettype wire
